### sv/tnorm_pkg.sv
package tnorm_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_WIDTH        = 16;

    localparam int EW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * EW;
    localparam int CPW = PW + 1;
    localparam int MW  = 31;
    localparam int XW  = (CPW > MW) ? CPW : MW;
    localparam int SHW = $clog2(XW + 1);
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW / 2;
    localparam int QW  = NORMAL_FRAC_BITS + 1;
    localparam int NW  = MW + NORMAL_FRAC_BITS + 1;
    localparam int DW  = ((NW > RW + QW) ? NW : RW + QW) + 1;
    localparam int QE  = QW + OUT_WIDTH;

    localparam int ISQ_STAGES = RW;
    localparam int DIV_STAGES = QW + 1;

    typedef struct packed {
        logic [2:0][MW-1:0] m;
        logic [2:0]         neg;
        logic               degen;
    } side_t;

    function automatic logic [OUT_WIDTH-1:0] sat_out(input logic neg, input logic [QW-1:0] q);
        logic [QE-1:0] qe;
        logic [QE-1:0] lim_pos;
        logic [QE-1:0] lim_neg;
        logic [QE-1:0] v;
        qe      = QE'(q);
        lim_pos = (QE'(1) << (OUT_WIDTH - 1)) - QE'(1);
        lim_neg = QE'(1) << (OUT_WIDTH - 1);
        if (neg && (q != '0)) begin
            v = (qe > lim_neg) ? lim_neg : qe;
            v = QE'(0) - v;
        end else begin
            v = (qe > lim_pos) ? lim_pos : qe;
        end
        return v[OUT_WIDTH-1:0];
    endfunction

endpackage

### sv/triangle_unit_normal_top.sv
// Cross product, scaling, square root, division and an output register run in that order;
// the square root takes one bit per stage.
// Throughput is one item per cycle; every stage advances together whenever the
// output register is empty or its item is taken.
// Reset (aresetn low at a clock edge) clears all valid bits; the data path is not reset.
module triangle_unit_normal_top
    import tnorm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up.
    input  logic [9*COORD_WIDTH-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // nx, ny, nz from the lowest bit up.
    output logic [3*OUT_WIDTH-1:0]     m_tdata,
    // degenerate.
    output logic                       m_tuser
);

    logic                       en;
    logic                       cr_vld, sc_vld, sq_vld, dv_vld;
    logic [2:0][CPW-1:0]        cr_c;
    logic [SW-1:0]              sc_sum;
    side_t                      sc_side, sq_side;
    logic [RW-1:0]              sq_root;
    logic [2:0][QW-1:0]         dv_q;
    logic [2:0]                 dv_neg;
    logic                       dv_degen;
    logic                       m_tvalid_reg;
    logic [3*OUT_WIDTH-1:0]     m_tdata_reg, m_tdata_next;
    logic                       m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    tnorm_cross u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (s_tvalid),
        .v_i     (s_tdata),
        .vld_o   (cr_vld),
        .c_o     (cr_c)
    );

    tnorm_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (cr_vld),
        .c_i     (cr_c),
        .vld_o   (sc_vld),
        .sum_o   (sc_sum),
        .side_o  (sc_side)
    );

    tnorm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (sc_vld),
        .sum_i   (sc_sum),
        .side_i  (sc_side),
        .vld_o   (sq_vld),
        .root_o  (sq_root),
        .side_o  (sq_side)
    );

    tnorm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (sq_vld),
        .root_i  (sq_root),
        .side_i  (sq_side),
        .vld_o   (dv_vld),
        .q_o     (dv_q),
        .neg_o   (dv_neg),
        .degen_o (dv_degen)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_tdata_next[i*OUT_WIDTH +: OUT_WIDTH] =
                dv_degen ? '0 : sat_out(dv_neg[i], dv_q[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dv_degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate item with nonzero normal");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

### sv/tnorm_cross.sv
module tnorm_cross
    import tnorm_pkg::*;
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                vld_i,
    input  logic [8:0][COORD_WIDTH-1:0]         v_i,
    output logic                                vld_o,
    output logic [2:0][CPW-1:0]                 c_o
);

    logic [2:0]                vld_reg;
    logic signed [EW-1:0]      e_reg [6];
    logic signed [EW-1:0]      e_next [6];
    logic signed [PW-1:0]      p_reg [6];
    logic signed [PW-1:0]      p_next [6];
    logic signed [CPW-1:0]     c_reg [3];
    logic signed [CPW-1:0]     c_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_next[i]     = $signed({v_i[i][COORD_WIDTH-1], v_i[i]})
                          - $signed({v_i[i+3][COORD_WIDTH-1], v_i[i+3]});
            e_next[i + 3] = $signed({v_i[i+3][COORD_WIDTH-1], v_i[i+3]})
                          - $signed({v_i[i+6][COORD_WIDTH-1], v_i[i+6]});
        end
        p_next[0] = e_reg[1] * e_reg[5];
        p_next[1] = e_reg[4] * e_reg[2];
        p_next[2] = e_reg[2] * e_reg[3];
        p_next[3] = e_reg[5] * e_reg[0];
        p_next[4] = e_reg[0] * e_reg[4];
        p_next[5] = e_reg[3] * e_reg[1];
        for (int i = 0; i < 3; i++) begin
            c_next[i] = CPW'(p_reg[2*i]) - CPW'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], vld_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg <= e_next;
            p_reg <= p_next;
            c_reg <= c_next;
        end
    end

    assign vld_o = vld_reg[2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_o[i] = c_reg[i];
        end
    end

endmodule

### sv/tnorm_scale.sv
module tnorm_scale
    import tnorm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_i,
    input  logic [2:0][CPW-1:0] c_i,
    output logic                vld_o,
    output logic [SW-1:0]       sum_o,
    output side_t               side_o
);

    logic [3:0]              vld_reg;
    logic [2:0][XW-1:0]      mag_reg, mag_next;
    logic [2:0]              neg_reg, neg_next;
    logic [SHW-1:0]          sh_reg, sh_next;
    logic                    degen_reg, degen_next;
    logic [XW-1:0]           or_w;
    logic [CPW-1:0]          abs_w;
    logic [XW-1:0]           shifted_w;
    side_t                   side5_reg, side5_next;
    side_t                   side6_reg, side7_reg;
    logic [2:0][SQW-1:0]     sq_reg, sq_next;
    logic [SW-1:0]           sum_reg, sum_next;

    always_comb begin
        or_w = '0;
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = c_i[i][CPW-1];
            abs_w       = c_i[i][CPW-1] ? (CPW'(0) - c_i[i]) : c_i[i];
            mag_next[i] = XW'(abs_w);
            or_w        = or_w | mag_next[i];
        end
        degen_next = (or_w == '0);
        sh_next    = '0;
        for (int j = MW; j < XW; j++) begin
            if (or_w[j]) begin
                sh_next = SHW'(j - MW + 1);
            end
        end

        for (int i = 0; i < 3; i++) begin
            shifted_w       = mag_reg[i] >> sh_reg;
            side5_next.m[i] = shifted_w[MW-1:0];
        end
        side5_next.neg   = neg_reg;
        side5_next.degen = degen_reg;

        for (int i = 0; i < 3; i++) begin
            sq_next[i] = SQW'(side5_reg.m[i]) * SQW'(side5_reg.m[i]);
        end
        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], vld_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            sh_reg    <= sh_next;
            degen_reg <= degen_next;
            side5_reg <= side5_next;
            sq_reg    <= sq_next;
            side6_reg <= side5_reg;
            sum_reg   <= sum_next;
            side7_reg <= side6_reg;
        end
    end

    assign vld_o  = vld_reg[3];
    assign sum_o  = sum_reg;
    assign side_o = side7_reg;

endmodule

### sv/tnorm_isqrt.sv
module tnorm_isqrt
    import tnorm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          vld_i,
    input  logic [SW-1:0] sum_i,
    input  side_t         side_i,
    output logic          vld_o,
    output logic [RW-1:0] root_o,
    output side_t         side_o
);

    logic [ISQ_STAGES-1:0] vld_reg;
    logic [SW-1:0]         s_reg    [ISQ_STAGES];
    logic [SW-1:0]         r_reg    [ISQ_STAGES];
    side_t                 side_reg [ISQ_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ISQ_STAGES-2:0], vld_i};
        end
    end

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_step
        localparam logic [SW-1:0] StepBit = SW'(1) << (SW - 2 - 2 * k);
        logic [SW-1:0] s_prev, r_prev, t_w, s_next, r_next;
        side_t         side_prev;

        if (k == 0) begin : g_first
            assign s_prev    = sum_i;
            assign r_prev    = '0;
            assign side_prev = side_i;
        end else begin : g_rest
            assign s_prev    = s_reg[k-1];
            assign r_prev    = r_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            t_w = r_prev + StepBit;
            if (s_prev >= t_w) begin
                s_next = s_prev - t_w;
                r_next = (r_prev >> 1) + StepBit;
            end else begin
                s_next = s_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[k]    <= s_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign vld_o  = vld_reg[ISQ_STAGES-1];
    assign root_o = r_reg[ISQ_STAGES-1][RW-1:0];
    assign side_o = side_reg[ISQ_STAGES-1];

endmodule

### sv/tnorm_div.sv
module tnorm_div
    import tnorm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_i,
    input  logic [RW-1:0]       root_i,
    input  side_t               side_i,
    output logic                vld_o,
    output logic [2:0][QW-1:0]  q_o,
    output logic [2:0]          neg_o,
    output logic                degen_o
);

    logic [DIV_STAGES-1:0]  vld_reg;
    logic [2:0][DW-1:0]     rem_reg  [DIV_STAGES];
    logic [2:0][QW-1:0]     q_reg    [DIV_STAGES];
    logic [RW-1:0]          root_reg [DIV_STAGES];
    side_t                  side_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], vld_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= (DW'(side_i.m[i]) << NORMAL_FRAC_BITS)
                               + DW'(root_i >> 1);
            end
            q_reg[0]    <= '0;
            root_reg[0] <= root_i;
            side_reg[0] <= side_i;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
        localparam int QBit = QW - k;
        logic [2:0][DW-1:0] rem_next;
        logic [2:0][QW-1:0] q_next;
        logic [DW-1:0]      dsh_w;

        always_comb begin
            dsh_w = DW'(root_reg[k-1]) << QBit;
            for (int i = 0; i < 3; i++) begin
                rem_next[i] = rem_reg[k-1][i];
                q_next[i]   = q_reg[k-1][i];
                if (rem_reg[k-1][i] >= dsh_w) begin
                    rem_next[i]     = rem_reg[k-1][i] - dsh_w;
                    q_next[i][QBit] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                root_reg[k] <= root_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign vld_o   = vld_reg[DIV_STAGES-1];
    assign q_o     = q_reg[DIV_STAGES-1];
    assign neg_o   = side_reg[DIV_STAGES-1].neg;
    assign degen_o = side_reg[DIV_STAGES-1].degen;

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_o && !degen_o |->
            (q_o[0] <= (QW'(1) << NORMAL_FRAC_BITS)) &&
            (q_o[1] <= (QW'(1) << NORMAL_FRAC_BITS)) &&
            (q_o[2] <= (QW'(1) << NORMAL_FRAC_BITS)))
        else $error("normal component above one");

endmodule
